FILE: rtl/core/tmlm_pkg.sv
// ----------------------------------------------------------------------------
// tmlm_pkg
// Shared widths, types, register indexes and constants of the trimmed-mean
// level meter.
// ----------------------------------------------------------------------------
package tmlm_pkg;

    // Samples per window (3 to 15)
    localparam int WINDOW_SIZE = 13;

    localparam int SAMPLE_W    = 12;
    localparam int LAMP_COUNT  = 6;
    localparam int SUM_W       = 16;
    localparam int COUNT_W     = 4;
    localparam int CFG_INDEX_W = 3;

    // Divide by WINDOW_SIZE - 2 as a multiply by a rounded-up reciprocal.
    // With a shift of SUM_W + 4 the quotient is exact for every SUM_W-bit sum.
    localparam int DIVISOR     = WINDOW_SIZE - 2;
    localparam int RECIP_SHIFT = SUM_W + 4;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    typedef logic [SAMPLE_W-1:0]   sample_t;
    typedef logic [SUM_W-1:0]      sum_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [LAMP_COUNT-1:0] lamps_t;
    typedef logic [LAMP_COUNT-1:0][SAMPLE_W-1:0] thr_array_t;

    localparam count_t COUNT_LAST = COUNT_W'(WINDOW_SIZE);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LEVEL_ONE   = 3'd0,
        REG_LEVEL_TWO   = 3'd1,
        REG_LEVEL_THREE = 3'd2,
        REG_LEVEL_FOUR  = 3'd3,
        REG_LEVEL_FIVE  = 3'd4,
        REG_LEVEL_SIX   = 3'd5
    } reg_index_t;

    // Threshold reset values, lamp 0 in the low slot
    localparam thr_array_t THR_RESET = {
        12'd2800, 12'd2750, 12'd2700, 12'd2650, 12'd2600, 12'd2550
    };

    // Trimmed window sum handed from the accumulator to the scaler
    typedef struct packed {
        logic valid;
        sum_t sum;
    } trim_t;

endpackage

FILE: rtl/core/tmlm_sample_if.sv
// ----------------------------------------------------------------------------
// tmlm_sample_if
// Sample channel: valid/ready handshake carrying one converter reading.
// ----------------------------------------------------------------------------
interface tmlm_sample_if;
    logic              valid;
    logic              ready;
    tmlm_pkg::sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

FILE: rtl/core/tmlm_result_if.sv
// ----------------------------------------------------------------------------
// tmlm_result_if
// Result channel: valid/ready handshake carrying the mean and lamp bits.
// ----------------------------------------------------------------------------
interface tmlm_result_if;
    logic              valid;
    logic              ready;
    tmlm_pkg::sample_t filtered_mean;
    tmlm_pkg::lamps_t  lamp_bits;

    modport source (output valid, output filtered_mean, output lamp_bits, input ready);
    modport sink   (input valid, input filtered_mean, input lamp_bits, output ready);
endinterface

FILE: rtl/core/tmlm_cfg_regs.sv
// ----------------------------------------------------------------------------
// tmlm_cfg_regs
// Six lamp threshold registers behind a plain write port.
// ----------------------------------------------------------------------------
module tmlm_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tmlm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  tmlm_pkg::sample_t                   cfg_data,
    output tmlm_pkg::thr_array_t                thresholds
);

    tmlm_pkg::thr_array_t thr_reg;

    // Write the addressed threshold; drop writes beyond the last register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= tmlm_pkg::THR_RESET;
        end
        else if (cfg_we)
        begin
            case (tmlm_pkg::reg_index_t'(cfg_index))
                tmlm_pkg::REG_LEVEL_ONE:   thr_reg[0] <= cfg_data;
                tmlm_pkg::REG_LEVEL_TWO:   thr_reg[1] <= cfg_data;
                tmlm_pkg::REG_LEVEL_THREE: thr_reg[2] <= cfg_data;
                tmlm_pkg::REG_LEVEL_FOUR:  thr_reg[3] <= cfg_data;
                tmlm_pkg::REG_LEVEL_FIVE:  thr_reg[4] <= cfg_data;
                tmlm_pkg::REG_LEVEL_SIX:   thr_reg[5] <= cfg_data;
                default:                   thr_reg    <= thr_reg;
            endcase
        end
    end

    assign thresholds = thr_reg;

endmodule

FILE: rtl/core/tmlm_accum.sv
// ----------------------------------------------------------------------------
// tmlm_accum
// Running sum, minimum, maximum and count of the current window; registers
// the trimmed sum when the window completes.
// ----------------------------------------------------------------------------
module tmlm_accum (
    input  logic                clk,
    input  logic                rst_n,
    tmlm_sample_if.sink         samples,
    output tmlm_pkg::trim_t     trim,
    input  logic                trim_ready
);

    tmlm_pkg::count_t  count_reg, count_next;
    tmlm_pkg::sum_t    sum_reg, sum_next;
    tmlm_pkg::sample_t min_reg, min_next;
    tmlm_pkg::sample_t max_reg, max_next;
    logic              trim_valid_reg;
    tmlm_pkg::sum_t    trim_sum_reg, trim_sum_next;
    logic              accept;
    logic              last;

    // Take a request whenever the trimmed-sum slot is free or draining
    assign samples.ready = !trim_valid_reg || trim_ready;
    assign accept        = samples.valid && samples.ready;

    // Fold the new sample into the window
    always_comb
    begin
        count_next    = count_reg + tmlm_pkg::count_t'(1);
        sum_next      = sum_reg + tmlm_pkg::SUM_W'(samples.sample);
        min_next      = (samples.sample < min_reg) ? samples.sample : min_reg;
        max_next      = (samples.sample > max_reg) ? samples.sample : max_reg;
        last          = (count_next == tmlm_pkg::COUNT_LAST);
        trim_sum_next = sum_next - tmlm_pkg::SUM_W'(min_next)
                                 - tmlm_pkg::SUM_W'(max_next);
    end

    // Advance the window state; restart it after the last sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                min_reg   <= '1;
                max_reg   <= '0;
            end
            else
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                min_reg   <= min_next;
                max_reg   <= max_next;
            end
        end
    end

    // Hold the trimmed sum until the scaler takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_valid_reg <= 1'b0;
        end
        else if (accept && last)
        begin
            trim_valid_reg <= 1'b1;
        end
        else if (trim_ready)
        begin
            trim_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last)
        begin
            trim_sum_reg <= trim_sum_next;
        end
    end

    assign trim.valid = trim_valid_reg;
    assign trim.sum   = trim_sum_reg;

endmodule

FILE: rtl/core/tmlm_scale.sv
// ----------------------------------------------------------------------------
// tmlm_scale
// Divides the trimmed sum by the window size less two, compares the mean
// with the thresholds and holds the result for the output channel.
// ----------------------------------------------------------------------------
module tmlm_scale (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tmlm_pkg::trim_t         trim,
    output logic                    trim_ready,
    input  tmlm_pkg::thr_array_t    thresholds,
    tmlm_result_if.source           results
);

    logic [tmlm_pkg::PROD_W-1:0] prod;
    tmlm_pkg::sample_t           mean;
    tmlm_pkg::lamps_t            lamps;
    logic                        out_valid_reg;
    tmlm_pkg::sample_t           mean_reg;
    tmlm_pkg::lamps_t            lamps_reg;
    logic                        load;

    assign trim_ready = !out_valid_reg || results.ready;
    assign load       = trim.valid && trim_ready;

    // Scale by the reciprocal and compare against each threshold
    always_comb
    begin
        prod = tmlm_pkg::PROD_W'(trim.sum) * tmlm_pkg::PROD_W'(tmlm_pkg::RECIP);
        mean = prod[tmlm_pkg::RECIP_SHIFT +: tmlm_pkg::SAMPLE_W];
        for (int k = 0; k < tmlm_pkg::LAMP_COUNT; k++)
        begin
            lamps[k] = (mean >= thresholds[k]);
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mean_reg  <= mean;
            lamps_reg <= lamps;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.filtered_mean = mean_reg;
    assign results.lamp_bits     = lamps_reg;

endmodule

FILE: rtl/core/trimmed_mean_level_meter.sv
// The trimmed sum loads at the edge that accepts the last sample of a window;
// the result register loads from it once the result slot is free or draining.
// Throughput: one sample per cycle while the trimmed-sum slot is free or draining;
// one result per WINDOW_SIZE samples. The rate is set by the running sum/min/max update.
// Reset (rst_n low, asynchronous) empties the window and both result slots
// and loads the six thresholds with their default levels.
// ----------------------------------------------------------------------------
// trimmed_mean_level_meter
// Window mean of converter samples with the smallest and largest dropped,
// plus six bar-graph lamp bits from programmable thresholds.
// ----------------------------------------------------------------------------
module trimmed_mean_level_meter (
    input  logic                                clk,
    input  logic                                rst_n,
    tmlm_sample_if.sink                         samples,
    tmlm_result_if.source                       results,
    input  logic                                cfg_we,
    input  logic [tmlm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  tmlm_pkg::sample_t                   cfg_data
);

    tmlm_pkg::thr_array_t thresholds;
    tmlm_pkg::trim_t      trim;
    logic                 trim_ready;

    tmlm_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .thresholds (thresholds)
    );

    tmlm_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .trim       (trim),
        .trim_ready (trim_ready)
    );

    tmlm_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .trim       (trim),
        .trim_ready (trim_ready),
        .thresholds (thresholds),
        .results    (results)
    );

endmodule

FILE: rtl/core/tmlm_checker.sv
// ----------------------------------------------------------------------------
// tmlm_checker
// Port-level checks of the level meter, bound to the top level.
// ----------------------------------------------------------------------------
module tmlm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input tmlm_pkg::sample_t                out_mean,
    input tmlm_pkg::lamps_t                 out_lamps,
    input logic                             cfg_we,
    input logic [tmlm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input tmlm_pkg::sample_t                cfg_data
);

    tmlm_pkg::count_t     seen_reg;
    logic [2:0]           pending_reg;
    tmlm_pkg::thr_array_t shadow_reg;
    tmlm_pkg::lamps_t     lamps_expect;
    logic                 in_acc;
    logic                 out_acc;
    logic                 window_done;

    assign in_acc      = in_valid && in_ready;
    assign out_acc     = out_valid && out_ready;
    assign window_done = in_acc
        && (seen_reg + tmlm_pkg::count_t'(1) == tmlm_pkg::COUNT_LAST);

    // Track window completions against delivered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                seen_reg <= window_done ? '0 : seen_reg + tmlm_pkg::count_t'(1);
            end
            pending_reg <= pending_reg + 3'(window_done) - 3'(out_acc);
        end
    end

    // Mirror the threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg <= tmlm_pkg::THR_RESET;
        end
        else if (cfg_we && (cfg_index < tmlm_pkg::CFG_INDEX_W'(tmlm_pkg::LAMP_COUNT)))
        begin
            shadow_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int k = 0; k < tmlm_pkg::LAMP_COUNT; k++)
        begin
            lamps_expect[k] = (out_mean >= shadow_reg[k]);
        end
    end

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_mean) && $stable(out_lamps))
        else $error("result dropped or changed while stalled");

    // Every delivered result belongs to a completed window
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pending_reg != 3'd0)
        else $error("result without a completed window");

    // Lamp bits agree with the mean and the programmed thresholds
    a_lamps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_lamps == lamps_expect)
        else $error("lamp bits disagree with thresholds");

    // An empty result slot never stalls the sample side
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("samples stalled with empty result slot");

endmodule

bind trimmed_mean_level_meter tmlm_checker u_tmlm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_mean  (results.filtered_mean),
    .out_lamps (results.lamp_bits),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trimmed-mean level meter. Streams windows of
// converter samples through the valid/ready channels under bursty input and
// stalling output, predicts each window mean and lamp pattern locally, and
// compares every reading in order across several threshold settings.
// ----------------------------------------------------------------------------
module tb_top;
    import tmlm_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int HOLDOFF_AT     = 700;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int MAX_REPORTS    = 10;
    localparam int PATTERN_LIFE   = 32;

    // Indexes past the last threshold register; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_HI = 3'd7;

    localparam reg_index_t LEVEL_REGS [LAMP_COUNT] = '{
        REG_LEVEL_ONE, REG_LEVEL_TWO, REG_LEVEL_THREE,
        REG_LEVEL_FOUR, REG_LEVEL_FIVE, REG_LEVEL_SIX
    };

    typedef enum {
        LEVELS_DEFAULT,
        LEVELS_FLOOR,
        LEVELS_CEILING,
        LEVELS_RAMP,
        LEVELS_SCATTER
    } level_plan_t;

    typedef struct packed {
        sample_t mean;
        lamps_t  lamps;
    } meter_reading_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    sample_t                cfg_data;

    tmlm_sample_if sample_ch ();
    tmlm_result_if result_ch ();

    trimmed_mean_level_meter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Sample requests waiting for the driver, readings waiting for the block
    sample_t        pending_samples [$];
    meter_reading_t expected_readings [$];

    // Local copy of the thresholds and the running window
    sample_t level_thr [LAMP_COUNT];
    count_t  win_count;
    sum_t    win_sum;
    sample_t win_low;
    sample_t win_high;

    // Window shaping for the random stream
    int fill_pos;
    int fill_mode;
    int fill_base;
    int fill_spread;

    int   samples_accepted;
    int   readings_checked;
    int   mismatches;
    int   cycle_count;
    logic sample_fire;

    // Sender burst state and receiver stall state
    int          burst_left;
    int          gap_left;
    int          holdoff_left;
    bit          holdoff_done;
    logic [15:0] stall_pattern;
    int          pattern_age;

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    function automatic void window_clear();
        win_count = '0;
        win_sum   = '0;
        win_low   = {SAMPLE_W{1'b1}};
        win_high  = '0;
    endfunction

    function automatic lamps_t lamps_for(input sample_t mean);
        lamps_t lit;
        lit = '0;
        for (int k = 0; k < LAMP_COUNT; k++)
        begin
            if (mean >= level_thr[k])
                lit[k] = 1'b1;
        end
        return lit;
    endfunction

    // Fold one sample into the window; a full window yields one reading
    function automatic void window_accumulate(input sample_t s);
        sum_t           trimmed;
        meter_reading_t reading;
        win_sum = win_sum + SUM_W'(s);
        if (s < win_low)
            win_low = s;
        if (s > win_high)
            win_high = s;
        win_count = win_count + 1'b1;
        if (win_count == COUNT_W'(WINDOW_SIZE))
        begin
            trimmed       = win_sum - SUM_W'(win_low) - SUM_W'(win_high);
            reading.mean  = sample_t'(trimmed / SUM_W'(WINDOW_SIZE - 2));
            reading.lamps = lamps_for(reading.mean);
            expected_readings.push_back(reading);
            window_clear();
        end
    endfunction

    task automatic write_level(input logic [CFG_INDEX_W-1:0] idx, input sample_t val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx < LAMP_COUNT)
            level_thr[idx] = val;
    endtask

    task automatic program_levels(input level_plan_t plan);
        int base;
        int step;
        int v;
        base = $urandom_range(0, 3000);
        step = $urandom_range(0, 200);
        for (int k = 0; k < LAMP_COUNT; k++)
        begin
            case (plan)
                LEVELS_FLOOR:   v = 0;
                LEVELS_CEILING: v = 4095;
                LEVELS_RAMP:    v = (base + k * step > 4095) ? 4095 : base + k * step;
                LEVELS_SCATTER: v = $urandom_range(0, 4095);
                default:        v = THR_RESET[k];
            endcase
            write_level(LEVEL_REGS[k], sample_t'(v));
        end
        // Poke the unused indexes; the thresholds must not move
        if (plan == LEVELS_FLOOR || plan == LEVELS_SCATTER)
        begin
            write_level(SPARE_INDEX_LO, sample_t'($urandom_range(0, 4095)));
            write_level(SPARE_INDEX_HI, sample_t'($urandom_range(0, 4095)));
        end
        @(posedge clk);
    endtask

    // Two windows: all at full scale, then both extremes doubled with a mean
    // landing exactly on the first default threshold
    task automatic queue_directed();
        for (int i = 0; i < WINDOW_SIZE; i++)
            pending_samples.push_back(sample_t'(4095));
        pending_samples.push_back(sample_t'(0));
        pending_samples.push_back(sample_t'(4095));
        pending_samples.push_back(sample_t'(0));
        pending_samples.push_back(sample_t'(4095));
        for (int i = 4; i < WINDOW_SIZE; i++)
            pending_samples.push_back(sample_t'(2662));
    endtask

    // Random windows, each with a character of its own
    task automatic queue_windows(input int count);
        int v;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            if (fill_pos == 0)
            begin
                fill_mode   = $urandom_range(0, 9);
                fill_base   = $urandom_range(0, 4095);
                fill_spread = $urandom_range(0, 80);
                if (fill_mode == 9)
                begin
                    fill_base   = level_thr[$urandom_range(0, LAMP_COUNT - 1)];
                    fill_spread = $urandom_range(0, 6);
                end
            end
            if (fill_mode >= 6 && fill_mode <= 7)
                v = $urandom_range(0, 4095);
            else if (fill_mode == 8)
            begin
                pick = $urandom_range(0, 2);
                v = (pick == 0) ? 0 : (pick == 1) ? 4095 : $urandom_range(0, 4095);
            end
            else
            begin
                v = fill_base + $urandom_range(0, 2 * fill_spread) - fill_spread;
                if (v < 0)
                    v = 0;
                if (v > 4095)
                    v = 4095;
            end
            pending_samples.push_back(sample_t'(v));
            fill_pos = (fill_pos + 1) % WINDOW_SIZE;
        end
    endtask

    // Wait until every request is taken and every reading has come back
    task automatic drain();
        while (pending_samples.size() != 0 || expected_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Sample both handshakes and check readings in order
    always @(posedge clk)
    begin : monitor
        meter_reading_t want;
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("trimmed_mean_level_meter regression: fail");
            $finish;
        end
        sample_fire <= rst_n && sample_ch.valid && sample_ch.ready;
        if (rst_n && sample_ch.valid && sample_ch.ready)
        begin
            window_accumulate(sample_ch.sample);
            if (pending_samples.size() != 0)
                void'(pending_samples.pop_front());
            samples_accepted = samples_accepted + 1;
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_readings.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected reading: mean=%0d lamps=%b",
                             result_ch.filtered_mean, result_ch.lamp_bits);
            end
            else
            begin
                want = expected_readings.pop_front();
                readings_checked = readings_checked + 1;
                if (result_ch.filtered_mean !== want.mean ||
                    result_ch.lamp_bits !== want.lamps)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("reading %0d mismatch: mean exp %0d got %0d, lamps exp %b got %b",
                                 readings_checked, want.mean, result_ch.filtered_mean,
                                 want.lamps, result_ch.lamp_bits);
                end
            end
        end
    end

    // Offer samples in bursts; hold a request until it is taken
    always @(negedge clk)
    begin : sample_driver
        if (!rst_n)
            sample_ch.valid <= 1'b0;
        else if (sample_ch.valid && !sample_fire)
        begin
            // hold the current request
        end
        else if (gap_left > 0)
        begin
            gap_left = gap_left - 1;
            sample_ch.valid <= 1'b0;
        end
        else if (pending_samples.size() == 0)
            sample_ch.valid <= 1'b0;
        else
        begin
            sample_ch.valid  <= 1'b1;
            sample_ch.sample <= pending_samples[0];
            if (burst_left > 1)
                burst_left = burst_left - 1;
            else
            begin
                burst_left = $urandom_range(1, 48);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
    end

    // Stall the output on a rotating pattern, with one long hold-off
    always @(negedge clk)
    begin : result_receiver
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (holdoff_left > 0)
        begin
            holdoff_left = holdoff_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (!holdoff_done && samples_accepted >= HOLDOFF_AT)
        begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES - 1;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (pattern_age == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = 16'hFFFF;
                    1:       stall_pattern = 16'($urandom);
                    2:       stall_pattern = 16'($urandom) | 16'($urandom);
                    default: stall_pattern = 16'($urandom) & 16'($urandom);
                endcase
                pattern_age = PATTERN_LIFE;
            end
            pattern_age = pattern_age - 1;
            result_ch.ready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    initial
    begin : stimulus
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_LEVEL_ONE;
        cfg_data         = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        result_ch.ready  = 1'b0;
        sample_fire      = 1'b0;
        samples_accepted = 0;
        readings_checked = 0;
        mismatches       = 0;
        cycle_count      = 0;
        burst_left       = 0;
        gap_left         = 0;
        holdoff_left     = 0;
        holdoff_done     = 1'b0;
        stall_pattern    = 16'hFFFF;
        pattern_age      = 0;
        fill_pos         = 0;
        fill_mode        = 0;
        fill_base        = 0;
        fill_spread      = 0;
        for (int k = 0; k < LAMP_COUNT; k++)
            level_thr[k] = THR_RESET[k];
        window_clear();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset thresholds first, then walk through the other settings
        queue_directed();
        drain();
        program_levels(LEVELS_FLOOR);
        queue_windows(250);
        drain();
        program_levels(LEVELS_CEILING);
        queue_windows(250);
        drain();
        program_levels(LEVELS_RAMP);
        queue_windows(400);
        drain();
        program_levels(LEVELS_SCATTER);
        queue_windows(400);
        drain();
        program_levels(LEVELS_DEFAULT);
        queue_windows(450);
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("streamed %0d samples under six threshold settings, %0d readings checked",
                 samples_accepted, readings_checked);
        $display("output held off %0d cycles once with input still offered; %0d mismatches",
                 HOLDOFF_CYCLES, mismatches);
        if (mismatches == 0)
            $display("trimmed_mean_level_meter regression: pass");
        else
            $display("trimmed_mean_level_meter regression: fail");
        $finish;
    end

endmodule
